[src/tto_pkg.sv]
// Shared codes and types for the timer table unit.
package tto_pkg;

	// Input item modes carried on s_tuser.
	localparam logic [2:0] MODE_REG_ONESHOT = 3'd0;
	localparam logic [2:0] MODE_REG_PERIODIC = 3'd1;
	localparam logic [2:0] MODE_CANCEL = 3'd2;
	localparam logic [2:0] MODE_TICK = 3'd3;
	localparam logic [2:0] MODE_CLEAR = 3'd4;
	localparam logic [2:0] MODE_RESET_STATS = 3'd5;

	// Widths of the stream words.
	localparam int IN_W = 48;
	localparam int OUT_W = 176;

	// Bit positions of result fields in m_tdata.
	localparam int OB_OK = 0;
	localparam int OB_EXP_VALID = 17;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_OUT = 3'b100
	} state_t;

endpackage

[src/tto_cell.sv]
// One timer slot cell of the rotating slot ring.
module tto_cell #(
	parameter int ID_BITS = 16,
	parameter int TIME_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 shift,
	input  logic                 in_used,
	input  logic [ID_BITS-1:0]   in_id,
	input  logic [TIME_BITS-1:0] in_expire,
	input  logic [31:0]          in_period,
	input  logic                 in_periodic,
	output logic                 used,
	output logic [ID_BITS-1:0]   id,
	output logic [TIME_BITS-1:0] expire,
	output logic [31:0]          period,
	output logic                 periodic
);

	logic                 used_q;
	logic [ID_BITS-1:0]   id_q;
	logic [TIME_BITS-1:0] expire_q;
	logic [31:0]          period_q;
	logic                 periodic_q;

	// The occupied flag is control state and clears on reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (shift) begin
			used_q <= in_used;
		end
	end

	// Slot contents follow the ring while it rotates.
	always_ff @(posedge clk) begin
		if (shift) begin
			id_q       <= in_id;
			expire_q   <= in_expire;
			period_q   <= in_period;
			periodic_q <= in_periodic;
		end
	end

	assign used     = used_q;
	assign id       = id_q;
	assign expire   = expire_q;
	assign period   = period_q;
	assign periodic = periodic_q;

endmodule

[src/timeout_table_one_shot_periodic_unit.sv]
// Timer table top level: slot ring, head-of-ring update logic and result sequencing.
//
// The block keeps SLOTS timer slots in a ring of cells and a millisecond clock. Each input
// word is taken in the idle state, then the ring rotates through all SLOTS cells, one slot per
// cycle, while the logic at the head of the ring places, cancels, expires or reschedules
// slots and gathers the earliest expiry and the occupancy. Then the results go out, one per
// cycle while the output is not stalled: one result, or one per expired timer of a tick.
// A new word is accepted only once the last result of the previous one has been taken.
module timeout_table_one_shot_periodic_unit import tto_pkg::*; #(
	parameter int SLOTS = 16,
	parameter int ID_BITS = 16,
	parameter int TIME_BITS = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// duration_ms[31:0], timer_id[47:32]
	input  logic [IN_W-1:0]   s_tdata,
	// mode[2:0]
	input  logic [2:0]        s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// ok[0], assigned_id[16:1], expired_valid[17], expired_id[33:18], expired_periodic[34],
	// next_timeout_ms[67:35], active_count[72:68], registered total[104:73],
	// trigger total[136:105], cancel total[168:137], zero fill[175:169]
	output logic [OUT_W-1:0]  m_tdata,
	output logic              m_tlast
);

	localparam int CW = $clog2(SLOTS + 1);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	state_t state_q;

	logic [TIME_BITS-1:0] now_q;
	logic [ID_BITS-1:0]   nid_q;
	logic [ID_BITS-1:0]   aid_q;
	logic [31:0]          reg_cnt_q;
	logic [31:0]          trig_cnt_q;
	logic [31:0]          canc_cnt_q;
	logic [2:0]           mode_q;
	logic [31:0]          dur_q;
	logic [15:0]          tid_q;
	logic                 done_q;
	logic                 any_q;
	logic [TIME_BITS-1:0] best_q;
	logic [CW-1:0]        act_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        wp_q;
	logic [CW-1:0]        rp_q;
	logic [ID_BITS-1:0]   ebuf_id_q [SLOTS];
	logic                 ebuf_prd_q [SLOTS];

	// Ring wiring: cell i loads from cell i+1, the last cell from the head logic.
	logic                 c_used [SLOTS];
	logic [ID_BITS-1:0]   c_id [SLOTS];
	logic [TIME_BITS-1:0] c_exp [SLOTS];
	logic [31:0]          c_per [SLOTS];
	logic                 c_prd [SLOTS];

	logic                 w_used;
	logic [ID_BITS-1:0]   w_id;
	logic [TIME_BITS-1:0] w_exp;
	logic [31:0]          w_per;
	logic                 w_prd;
	logic                 shift;

	assign shift = (state_q == ST_SCAN);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		if (i == SLOTS - 1) begin : g_tail
			tto_cell #(.ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n), .shift(shift),
				.in_used(w_used), .in_id(w_id), .in_expire(w_exp),
				.in_period(w_per), .in_periodic(w_prd),
				.used(c_used[i]), .id(c_id[i]), .expire(c_exp[i]),
				.period(c_per[i]), .periodic(c_prd[i])
			);
		end else begin : g_mid
			tto_cell #(.ID_BITS(ID_BITS), .TIME_BITS(TIME_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n), .shift(shift),
				.in_used(c_used[i+1]), .in_id(c_id[i+1]), .in_expire(c_exp[i+1]),
				.in_period(c_per[i+1]), .in_periodic(c_prd[i+1]),
				.used(c_used[i]), .id(c_id[i]), .expire(c_exp[i]),
				.period(c_per[i]), .periodic(c_prd[i])
			);
		end
	end

	// Head-of-ring update for the slot now at cell zero.
	logic [TIME_BITS-1:0] rem;
	logic                 due;
	logic                 take;
	logic                 fire;
	logic                 fresh;
	logic [TIME_BITS-1:0] contrib;
	logic                 is_reg;

	assign is_reg = (mode_q == MODE_REG_ONESHOT) || (mode_q == MODE_REG_PERIODIC);
	assign rem    = c_exp[0] - now_q;
	assign due    = (rem == '0) || rem[TIME_BITS-1];

	always_comb begin
		w_used = c_used[0];
		w_id   = c_id[0];
		w_exp  = c_exp[0];
		w_per  = c_per[0];
		w_prd  = c_prd[0];
		take   = 1'b0;
		fire   = 1'b0;
		fresh  = 1'b0;
		case (mode_q)
			MODE_REG_ONESHOT, MODE_REG_PERIODIC: begin
				if (!c_used[0] && !done_q && (dur_q != 32'd0)) begin
					w_used = 1'b1;
					w_id   = nid_q;
					w_exp  = now_q + TIME_BITS'(dur_q);
					w_per  = dur_q;
					w_prd  = (mode_q == MODE_REG_PERIODIC);
					take   = 1'b1;
					fresh  = 1'b1;
				end
			end
			MODE_CANCEL: begin
				if (c_used[0] && !done_q && (tid_q != 16'd0) &&
						(32'(c_id[0]) == 32'(tid_q))) begin
					w_used = 1'b0;
					take   = 1'b1;
				end
			end
			MODE_TICK: begin
				if (c_used[0] && due) begin
					fire = 1'b1;
					if (c_prd[0]) begin
						w_exp = now_q + TIME_BITS'(c_per[0]);
						fresh = 1'b1;
					end else begin
						w_used = 1'b0;
					end
				end
			end
			MODE_CLEAR: begin
				w_used = 1'b0;
			end
			default: begin
			end
		endcase
		// A freshly scheduled slot is due exactly its period from now.
		if (fresh) begin
			contrib = TIME_BITS'(w_per);
		end else if (due) begin
			contrib = '0;
		end else begin
			contrib = rem;
		end
	end

	// Id after the one just handed out, skipping zero.
	logic [ID_BITS-1:0] nid_inc;
	assign nid_inc = nid_q + ID_BITS'(1);

	logic out_fire;
	logic out_last;
	assign out_fire = m_tvalid && m_tready;
	assign out_last = (wp_q == '0) || (rp_q == wp_q - CW'(1));

	// Controller: accept, rotate the ring once, then emit results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			now_q      <= '0;
			nid_q      <= ID_BITS'(1);
			reg_cnt_q  <= '0;
			trig_cnt_q <= '0;
			canc_cnt_q <= '0;
			mode_q     <= MODE_CLEAR;
			done_q     <= 1'b0;
			any_q      <= 1'b0;
			best_q     <= '0;
			act_q      <= '0;
			cnt_q      <= '0;
			wp_q       <= '0;
			rp_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q <= s_tuser;
						done_q <= 1'b0;
						any_q  <= 1'b0;
						act_q  <= '0;
						cnt_q  <= '0;
						wp_q   <= '0;
						rp_q   <= '0;
						if (s_tuser == MODE_TICK) begin
							now_q <= now_q + TIME_BITS'(1);
						end
						if (s_tuser == MODE_RESET_STATS) begin
							reg_cnt_q  <= '0;
							trig_cnt_q <= '0;
							canc_cnt_q <= '0;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (take) begin
						done_q <= 1'b1;
						if (is_reg) begin
							reg_cnt_q <= reg_cnt_q + 32'd1;
							nid_q     <= (nid_inc == '0) ? ID_BITS'(1) : nid_inc;
						end else begin
							canc_cnt_q <= canc_cnt_q + 32'd1;
						end
					end
					if (fire) begin
						trig_cnt_q <= trig_cnt_q + 32'd1;
						wp_q       <= wp_q + CW'(1);
					end
					if (w_used) begin
						act_q <= act_q + CW'(1);
						any_q <= 1'b1;
						if (!any_q || (contrib < best_q)) begin
							best_q <= contrib;
						end
					end
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(SLOTS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_fire) begin
						if (out_last) begin
							state_q <= ST_IDLE;
						end else begin
							rp_q <= rp_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand capture and expiry list; payload only, no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			dur_q <= s_tdata[31:0];
			tid_q <= s_tdata[47:32];
			aid_q <= '0;
		end
		if (shift && take && is_reg) begin
			aid_q <= nid_q;
		end
		if (shift && fire) begin
			ebuf_id_q[wp_q[IW-1:0]]  <= c_id[0];
			ebuf_prd_q[wp_q[IW-1:0]] <= c_prd[0];
		end
	end

	// Result word assembly.
	logic        r_ok;
	logic        r_ev;
	logic [31:0] aid_ext;
	logic [31:0] eid_ext;
	logic        r_ep;
	logic [32:0] r_next;
	logic [31:0] act_ext;

	always_comb begin
		case (mode_q)
			MODE_REG_ONESHOT, MODE_REG_PERIODIC, MODE_CANCEL: r_ok = done_q;
			MODE_TICK, MODE_CLEAR, MODE_RESET_STATS: r_ok = 1'b1;
			default: r_ok = 1'b0;
		endcase
		r_ev    = (wp_q != '0);
		aid_ext = 32'(aid_q);
		eid_ext = r_ev ? 32'(ebuf_id_q[rp_q[IW-1:0]]) : 32'd0;
		r_ep    = r_ev && ebuf_prd_q[rp_q[IW-1:0]];
		r_next  = any_q ? best_q[32:0] : '1;
		act_ext = 32'(act_q);
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tlast  = out_last;
	assign m_tdata  = {7'd0, canc_cnt_q, trig_cnt_q, reg_cnt_q, act_ext[4:0], r_next,
		r_ep, eid_ext[15:0], r_ev, aid_ext[15:0], r_ok};

endmodule

[src/tto_chk.sv]
// Port-level checker for the timer table unit, bound to the top level.
module tto_chk import tto_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [IN_W-1:0]   s_tdata,
	input logic [2:0]        s_tuser,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [OUT_W-1:0]  m_tdata,
	input logic              m_tlast
);

	// No new word is taken while a result is pending.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while a result is pending");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled result changed");

	// A result without an expiry is always the only one of its word.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[OB_EXP_VALID]) |-> m_tlast)
		else $error("non-expiry result not marked last");

	// Every expiry report comes with ok set.
	a_exp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[OB_EXP_VALID]) |-> m_tdata[OB_OK])
		else $error("expiry result without ok");

endmodule

bind timeout_table_one_shot_periodic_unit tto_chk u_tto_chk (.*);
